/* src/mpp_pkg.sv */
// shared types, constants and register codes for the max pooling block
package mpp_pkg;

  // axis positions, counts and window ends, sized for the largest plane and kernel
  localparam int AXIS_W = 14;
  // kernel side and row slot width, sized for the largest kernel
  localparam int KW = 4;
  // output index width
  localparam int IDX_W = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_KERNEL = 7;
  localparam int DEF_SAMPLE_BITS = 16;

  // register reset values
  localparam logic [2:0] KERNEL_RST = 3'd3;
  localparam logic [2:0] STRIDE_RST = 3'd2;
  localparam logic [1:0] PADDING_RST = 2'd1;
  localparam logic [10:0] HEIGHT_RST = 11'd1024;
  localparam logic [10:0] WIDTH_RST = 11'd1024;
  localparam logic [15:0] PAD_VALUE_RST = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL    = 3'd0,
    REG_STRIDE    = 3'd1,
    REG_PADDING   = 3'd2,
    REG_HEIGHT    = 3'd3,
    REG_WIDTH     = 3'd4,
    REG_PAD_VALUE = 3'd5
  } reg_idx_t;

  typedef logic [AXIS_W-1:0] axis_t;

  // effective (clamped) geometry
  typedef struct packed {
    logic [KW-1:0] k;
    logic [2:0]    s;
    logic [1:0]    p;
    axis_t         h;
    axis_t         w;
  } cfg_t;

  // one released group of windows: rows rlo..rlo+rn-1 by cols clo..clo+cn-1
  typedef struct packed {
    axis_t         row;
    logic [KW-1:0] slot;
    axis_t         rlo;
    axis_t         rn;
    axis_t         clo;
    axis_t         cn;
    axis_t         hout;
    axis_t         wout;
  } job_t;

endpackage

/* src/mpp_ram.sv */
// generic simple dual port ram, one write port, one registered read port
module mpp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/mpp_fifo.sv */
// small synchronous fifo
module mpp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

/* src/mpp_front.sv */
// front end: takes samples, stores them in the line memory, finds released windows
module mpp_front import mpp_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_KERNEL = DEF_MAX_KERNEL,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int SW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   cfg_wr,
  input  logic                   push,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   full,
  input  logic                   back_busy,
  output logic                   mem_we,
  output logic [SW+CW-1:0]       mem_waddr,
  output logic [SAMPLE_BITS-1:0] mem_wdata,
  output logic                   job_push,
  output job_t                   job
);

  localparam int DCW = $clog2(AXIS_W);

  typedef enum logic [1:0] {ST_LOAD, ST_DIV, ST_RUN} state_t;

  state_t        state;
  axis_t         row, col, re, ridx, ce, cidx;
  logic [KW-1:0] slot;
  axis_t         dnum_h, dnum_w;
  logic [2:0]    drem_h, drem_w;
  logic          neg_h, neg_w;
  logic [DCW-1:0] dcnt;

  logic [AXIS_W:0] nh, nw;
  axis_t         hout, wout, end0;
  axis_t         rlo, rn, clo, cn;
  logic          acc, col_last, row_last, col_hit, row_hit;
  logic [AXIS_W+2:0] step_h, step_w;

  // one restoring division step: quotient bits shift into the low end
  function automatic logic [AXIS_W+2:0] div_step(input axis_t num, input logic [2:0] rem,
                                                 input logic [2:0] s);
    logic [3:0] sh;
    logic [2:0] r;
    logic       qb;
    sh = {rem, num[AXIS_W-1]};
    if (sh >= {1'b0, s}) begin
      r  = 3'(sh - {1'b0, s});
      qb = 1'b1;
    end else begin
      r  = sh[2:0];
      qb = 1'b0;
    end
    return {num[AXIS_W-2:0], qb, r};
  endfunction

  assign nh = (AXIS_W+1)'(cfg.h) + (AXIS_W+1)'({cfg.p, 1'b0}) - (AXIS_W+1)'(cfg.k);
  assign nw = (AXIS_W+1)'(cfg.w) + (AXIS_W+1)'({cfg.p, 1'b0}) - (AXIS_W+1)'(cfg.k);
  assign end0 = AXIS_W'(cfg.k) - AXIS_W'(cfg.p) - 1'b1;
  assign hout = neg_h ? '0 : dnum_h + 1'b1;
  assign wout = neg_w ? '0 : dnum_w + 1'b1;
  assign step_h = div_step(dnum_h, drem_h, cfg.s);
  assign step_w = div_step(dnum_w, drem_w, cfg.s);

  assign full = (state != ST_RUN) || back_busy;
  assign acc  = push && !full;

  assign col_last = (col == cfg.w - 1'b1);
  assign row_last = (row == cfg.h - 1'b1);
  assign col_hit  = (col == ce) && (cidx < wout);
  assign row_hit  = (row == re) && (ridx < hout);

  always_comb begin
    clo = cidx;
    rlo = ridx;
    if (col_last) begin
      cn = (cidx < wout) ? wout - cidx : '0;
    end else begin
      cn = col_hit ? AXIS_W'(1) : '0;
    end
    if (row_last) begin
      rn = (ridx < hout) ? hout - ridx : '0;
    end else begin
      rn = row_hit ? AXIS_W'(1) : '0;
    end
  end

  assign mem_we    = acc;
  assign mem_waddr = {slot[SW-1:0], col[CW-1:0]};
  assign mem_wdata = sample;
  assign job_push  = acc && (rn != '0) && (cn != '0);
  assign job = '{row: row, slot: slot, rlo: rlo, rn: rn, clo: clo, cn: cn,
                 hout: hout, wout: wout};

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      state <= ST_LOAD;
    end else begin
      case (state)
        ST_LOAD: begin
          neg_h  <= nh[AXIS_W];
          neg_w  <= nw[AXIS_W];
          dnum_h <= nh[AXIS_W-1:0];
          dnum_w <= nw[AXIS_W-1:0];
          drem_h <= '0;
          drem_w <= '0;
          dcnt   <= '0;
          row    <= '0;
          col    <= '0;
          slot   <= '0;
          re     <= end0;
          ce     <= end0;
          ridx   <= '0;
          cidx   <= '0;
          state  <= ST_DIV;
        end
        ST_DIV: begin
          dnum_h <= step_h[AXIS_W+2:3];
          drem_h <= step_h[2:0];
          dnum_w <= step_w[AXIS_W+2:3];
          drem_w <= step_w[2:0];
          dcnt   <= dcnt + 1'b1;
          if (dcnt == DCW'(AXIS_W - 1)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (acc) begin
            if (col_last) begin
              col  <= '0;
              ce   <= end0;
              cidx <= '0;
              if (row_last) begin
                row  <= '0;
                slot <= '0;
                re   <= end0;
                ridx <= '0;
              end else begin
                row  <= row + 1'b1;
                slot <= (slot == cfg.k - 1'b1) ? '0 : slot + 1'b1;
                if (row_hit) begin
                  re   <= re + AXIS_W'(cfg.s);
                  ridx <= ridx + 1'b1;
                end
              end
            end else begin
              col <= col + 1'b1;
              if (col_hit) begin
                ce   <= ce + AXIS_W'(cfg.s);
                cidx <= cidx + 1'b1;
              end
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

/* src/mpp_back.sv */
// back end: walks each released window through the line memory and takes its maximum
module mpp_back import mpp_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_KERNEL = DEF_MAX_KERNEL,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int SW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic signed [SAMPLE_BITS-1:0] padv,
  input  logic                          job_empty,
  output logic                          job_pop,
  input  job_t                          job,
  output logic                          active,
  output logic [SW+CW-1:0]              mem_raddr,
  input  logic [SAMPLE_BITS-1:0]        mem_rdata,
  input  logic                          res_full,
  output logic                          res_push,
  output logic signed [SAMPLE_BITS-1:0] pooled_value,
  output logic [IDX_W-1:0]              out_row,
  output logic [IDX_W-1:0]              out_col,
  output logic                          last_in_run,
  output logic                          last_of_plane
);

  typedef enum logic [1:0] {ST_IDLE, ST_WIN, ST_RD, ST_FIN} state_t;

  state_t          state;
  job_t            jb;
  axis_t           a, b;
  logic [AXIS_W:0] i0, j0;
  logic [KW-1:0]   ki, kj;
  logic            rd_v, rd_pad, rd_first;
  logic signed [SAMPLE_BITS-1:0] mx;

  axis_t           r_cur, c_cur, r_prod, c_prod;
  logic [AXIS_W:0] y, x, drow;
  logic [KW-1:0]   d, slot_c;
  logic            pad, elem_last;
  logic signed [SAMPLE_BITS-1:0] val, mx_next;

  assign r_cur  = jb.rlo + a;
  assign c_cur  = jb.clo + b;
  assign r_prod = r_cur * AXIS_W'(cfg.s);
  assign c_prod = c_cur * AXIS_W'(cfg.s);

  assign y = i0 + (AXIS_W+1)'(ki);
  assign x = j0 + (AXIS_W+1)'(kj);
  assign pad = y[AXIS_W] || (y[AXIS_W-1:0] >= cfg.h) ||
               x[AXIS_W] || (x[AXIS_W-1:0] >= cfg.w);

  // rows of the window lie within the last k rows, so the slot is a short step back
  assign drow   = (AXIS_W+1)'(jb.row) - y;
  assign d      = drow[KW-1:0];
  assign slot_c = (jb.slot >= d) ? jb.slot - d : jb.slot + (cfg.k - d);
  assign mem_raddr = {slot_c[SW-1:0], x[CW-1:0]};

  assign elem_last = (ki == cfg.k - 1'b1) && (kj == cfg.k - 1'b1);

  assign val     = rd_pad ? padv : $signed(mem_rdata);
  assign mx_next = (rd_first || val > mx) ? val : mx;

  assign active   = (state != ST_IDLE);
  assign job_pop  = (state == ST_IDLE) && !job_empty;
  assign res_push = (state == ST_FIN);

  assign pooled_value  = mx_next;
  assign out_row       = r_cur[IDX_W-1:0];
  assign out_col       = c_cur[IDX_W-1:0];
  assign last_in_run   = (a == jb.rn - 1'b1) && (b == jb.cn - 1'b1);
  assign last_of_plane = (r_cur == jb.hout - 1'b1) && (c_cur == jb.wout - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rd_v  <= 1'b0;
    end else begin
      rd_v <= (state == ST_RD);
      if (rd_v) begin
        mx <= mx_next;
      end
      case (state)
        ST_IDLE: begin
          if (!job_empty) begin
            jb    <= job;
            a     <= '0;
            b     <= '0;
            state <= ST_WIN;
          end
        end
        ST_WIN: begin
          if (!res_full) begin
            i0    <= {1'b0, r_prod} - (AXIS_W+1)'(cfg.p);
            j0    <= {1'b0, c_prod} - (AXIS_W+1)'(cfg.p);
            ki    <= '0;
            kj    <= '0;
            state <= ST_RD;
          end
        end
        ST_RD: begin
          rd_pad   <= pad;
          rd_first <= (ki == '0) && (kj == '0);
          if (kj == cfg.k - 1'b1) begin
            kj <= '0;
            ki <= ki + 1'b1;
          end else begin
            kj <= kj + 1'b1;
          end
          if (elem_last) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (b == jb.cn - 1'b1) begin
            b <= '0;
            if (a == jb.rn - 1'b1) begin
              state <= ST_IDLE;
            end else begin
              a     <= a + 1'b1;
              state <= ST_WIN;
            end
          end else begin
            b     <= b + 1'b1;
            state <= ST_WIN;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* src/max_pool_2d_padded.sv */
// streaming 2-d max pooling with constant padding, top level
// a sample that closes windows queues them as a job; the back end reads each window's k*k
//   positions from the line memory in turn and queues its maximum, one window after another
// throughput: one sample per cycle while no window is pending; a sample that releases
//   windows holds the input full until the back end has read them all, set by the one read
//   port of the line memory
// reset and every known register write recompute the output plane size with a serial
//   divider, input held full until it is done; position counters restart at a new plane
module max_pool_2d_padded import mpp_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_KERNEL = DEF_MAX_KERNEL,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  // sample words in
  input  logic                          push,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          full,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  // pooled words out
  output logic                          empty,
  input  logic                          pop,
  output logic signed [SAMPLE_BITS-1:0] pooled_value,
  output logic [IDX_W-1:0]              out_row,
  output logic [IDX_W-1:0]              out_col,
  output logic                          last_in_run,
  output logic                          last_of_plane
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int SW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int MEM_DEPTH = MAX_KERNEL * (2 ** CW);
  localparam int MEM_AW = $clog2(MEM_DEPTH);
  localparam int RES_W = SAMPLE_BITS + 2 * IDX_W + 2;
  localparam int JOB_W = $bits(job_t);

  // configuration registers, raw as written
  logic [2:0]  kernel_len;
  logic [2:0]  stride;
  logic [1:0]  padding;
  logic [10:0] plane_height;
  logic [10:0] plane_width;
  logic [15:0] pad_value;
  logic        cfg_wr;

  cfg_t                          cfg;
  logic [KW-1:0]                 k_eff;
  logic signed [SAMPLE_BITS-1:0] padv;

  // front to back
  logic        job_push, job_full, job_pop, job_empty;
  job_t        job_in, job_out;
  logic        back_active, back_busy;

  // line memory
  logic                   mem_we;
  logic [SW+CW-1:0]       mem_waddr, mem_raddr;
  logic [SAMPLE_BITS-1:0] mem_wdata, mem_rdata;

  // result queue
  logic                          res_push, res_full;
  logic signed [SAMPLE_BITS-1:0] b_value;
  logic [IDX_W-1:0]              b_row, b_col;
  logic                          b_last_run, b_last_plane;
  logic [RES_W-1:0]              res_out;

  assign cfg_ready = 1'b1;

  // register writes; an unknown index changes nothing
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_len   <= KERNEL_RST;
      stride       <= STRIDE_RST;
      padding      <= PADDING_RST;
      plane_height <= HEIGHT_RST;
      plane_width  <= WIDTH_RST;
      pad_value    <= PAD_VALUE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KERNEL:    kernel_len   <= cfg_data[2:0];
        REG_STRIDE:    stride       <= cfg_data[2:0];
        REG_PADDING:   padding      <= cfg_data[1:0];
        REG_HEIGHT:    plane_height <= cfg_data[10:0];
        REG_WIDTH:     plane_width  <= cfg_data[10:0];
        REG_PAD_VALUE: pad_value    <= cfg_data;
        default: ;
      endcase
    end
  end

  // any write to a known register restarts the plane
  assign cfg_wr = cfg_valid && (cfg_index == REG_KERNEL || cfg_index == REG_STRIDE ||
                                cfg_index == REG_PADDING || cfg_index == REG_HEIGHT ||
                                cfg_index == REG_WIDTH || cfg_index == REG_PAD_VALUE);

  // clamp the geometry: kernel 1..max, stride at least 1, padding at most k/2,
  // plane sides 1..max
  always_comb begin
    if (kernel_len == '0) begin
      k_eff = KW'(1);
    end else if (KW'(kernel_len) > KW'(MAX_KERNEL)) begin
      k_eff = KW'(MAX_KERNEL);
    end else begin
      k_eff = KW'(kernel_len);
    end
    cfg.k = k_eff;
    cfg.s = (stride == '0) ? 3'd1 : stride;
    cfg.p = (KW'(padding) > (k_eff >> 1)) ? 2'(k_eff >> 1) : padding;
    if (plane_height == '0) begin
      cfg.h = AXIS_W'(1);
    end else if (AXIS_W'(plane_height) > AXIS_W'(MAX_HEIGHT)) begin
      cfg.h = AXIS_W'(MAX_HEIGHT);
    end else begin
      cfg.h = AXIS_W'(plane_height);
    end
    if (plane_width == '0) begin
      cfg.w = AXIS_W'(1);
    end else if (AXIS_W'(plane_width) > AXIS_W'(MAX_WIDTH)) begin
      cfg.w = AXIS_W'(MAX_WIDTH);
    end else begin
      cfg.w = AXIS_W'(plane_width);
    end
  end

  assign padv = SAMPLE_BITS'($signed(pad_value));

  // the line memory has one write and one read port, so the front waits for the
  // back to drain before it writes a sample that could overwrite a pending row
  assign back_busy = back_active || !job_empty;

  mpp_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_KERNEL(MAX_KERNEL),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .cfg_wr(cfg_wr),
    .push(push),
    .sample(sample),
    .full(full),
    .back_busy(back_busy),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .job_push(job_push),
    .job(job_in)
  );

  mpp_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(2)
  ) u_job_q (
    .clk(clk),
    .rst(rst),
    .push(job_push),
    .wdata(job_in),
    .full(job_full),
    .pop(job_pop),
    .rdata(job_out),
    .empty(job_empty)
  );

  // MAX_KERNEL row slots, each MAX_WIDTH rounded up to a power of two
  mpp_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MEM_DEPTH)
  ) u_line_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr[MEM_AW-1:0]),
    .wdata(mem_wdata),
    .raddr(mem_raddr[MEM_AW-1:0]),
    .rdata(mem_rdata)
  );

  mpp_back #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_KERNEL(MAX_KERNEL),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .padv(padv),
    .job_empty(job_empty),
    .job_pop(job_pop),
    .job(job_out),
    .active(back_active),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata),
    .res_full(res_full),
    .res_push(res_push),
    .pooled_value(b_value),
    .out_row(b_row),
    .out_col(b_col),
    .last_in_run(b_last_run),
    .last_of_plane(b_last_plane)
  );

  // output queue decouples the window walk from the consumer
  mpp_fifo #(
    .WIDTH(RES_W),
    .DEPTH(2)
  ) u_res_q (
    .clk(clk),
    .rst(rst),
    .push(res_push),
    .wdata({b_value, b_row, b_col, b_last_run, b_last_plane}),
    .full(res_full),
    .pop(pop),
    .rdata(res_out),
    .empty(empty)
  );

  assign pooled_value  = $signed(res_out[RES_W-1 -: SAMPLE_BITS]);
  assign out_row       = res_out[2*IDX_W+1 -: IDX_W];
  assign out_col       = res_out[IDX_W+1 -: IDX_W];
  assign last_in_run   = res_out[1];
  assign last_of_plane = res_out[0];

`ifndef ASSERT_OFF
  // the front never writes the line memory while a window walk is pending
  a_no_write_while_busy: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !back_active && job_empty)
    else $error("sample stored while windows pending");

  // the job queue never overflows
  a_job_no_overflow: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !job_full)
    else $error("job queue overflow");

  // a finished window always finds room in the output queue
  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result queue overflow");

  // a register write holds off input while the plane size is recomputed
  a_cfg_holds_input: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> full)
    else $error("input taken during geometry update");
`endif

endmodule

/* tb/max_pool_2d_padded_test.sv */
// self-checking testbench for the streaming 2-d max pooling block
module max_pool_2d_padded_test;
  import mpp_pkg::*;

  localparam int LINE_W = 1024;
  localparam int HANG_LIMIT = 4000;
  // idle wait after the last expected word has been checked
  localparam int SETTLE_CYCLES = 60;
  localparam int RAND_ITEMS = 150;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

  // one directed stimulus row; want is only used where typed is set
  typedef struct {
    row_kind_t   kind;
    logic [2:0]  idx;
    logic [15:0] data;
    bit          typed;
    logic [15:0] want;
  } stim_row_t;

  typedef struct {
    logic signed [15:0] value;
    logic [9:0]         row;
    logic [9:0]         col;
    logic               last_run;
    logic               last_plane;
  } window_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic signed [15:0] sample = '0;
  logic full;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [15:0] pooled_value;
  logic [9:0] out_row, out_col;
  logic last_in_run, last_of_plane;

  max_pool_2d_padded dut (
    .clk(clk), .rst(rst),
    .push(push), .sample(sample), .full(full),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .empty(empty), .pop(pop), .pooled_value(pooled_value),
    .out_row(out_row), .out_col(out_col),
    .last_in_run(last_in_run), .last_of_plane(last_of_plane)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: raw registers, plane position and the stored rows
  logic [2:0]  kernel_reg;
  logic [2:0]  stride_reg;
  logic [1:0]  padding_reg;
  logic [10:0] height_reg;
  logic [10:0] width_reg;
  logic signed [15:0] pad_reg;
  int pos_row, pos_col;
  logic signed [15:0] row_store [0:7*LINE_W-1];

  window_t pending_windows[$];
  int errors = 0;
  int samples_in = 0;
  int windows_out = 0;
  int quiet_cycles = 0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d (window %0d)", what, got, want, windows_out);
    errors++;
  endtask

  // output indices on one axis whose windows end at position pos
  function automatic int axis_span(input int pos, input int n, input int cnt, input int k,
                                   input int s, input int p, output int lo);
    int t, first;
    lo = 0;
    if (cnt <= 0) return 0;
    if (pos < n - 1) begin
      t = pos - k + 1 + p;
      if (t < 0 || (t % s) != 0 || t / s >= cnt) return 0;
      lo = t / s;
      return 1;
    end
    t = n - k + p;
    first = (t <= 0) ? 0 : (t + s - 1) / s;
    if (first > cnt - 1) return 0;
    lo = first;
    return cnt - first;
  endfunction

  // store one sample and queue every window it closes; returns the window count
  function automatic int pool_predict(input logic signed [15:0] smp);
    int k, s, p, h, w, hout, wout, rlo, clo, rn, cn, r, c, y, x, n;
    logic signed [15:0] m, v;
    window_t win;
    k = kernel_reg; s = stride_reg; p = padding_reg; h = height_reg; w = width_reg;
    n = 0;
    if (k < 1) k = 1;
    if (s < 1) s = 1;
    if (p > k / 2) p = k / 2;
    if (h < 1) h = 1;
    if (h > 1024) h = 1024;
    if (w < 1) w = 1;
    if (w > 1024) w = 1024;
    if (pos_row >= h) pos_row = 0;
    if (pos_col >= w) pos_col = 0;
    row_store[(pos_row % k) * LINE_W + pos_col] = smp;
    hout = (h + 2 * p >= k) ? (h + 2 * p - k) / s + 1 : 0;
    wout = (w + 2 * p >= k) ? (w + 2 * p - k) / s + 1 : 0;
    rn = axis_span(pos_row, h, hout, k, s, p, rlo);
    cn = axis_span(pos_col, w, wout, k, s, p, clo);
    for (int a = 0; a < rn; a++) begin
      for (int b = 0; b < cn; b++) begin
        r = rlo + a;
        c = clo + b;
        m = pad_reg;
        for (int ki = 0; ki < k; ki++) begin
          for (int kj = 0; kj < k; kj++) begin
            y = r * s - p + ki;
            x = c * s - p + kj;
            if (y < 0 || y >= h || x < 0 || x >= w) v = pad_reg;
            else v = row_store[(y % k) * LINE_W + x];
            // first position seeds the max
            if ((ki == 0 && kj == 0) || v > m) m = v;
          end
        end
        win.value = m;
        win.row = r[9:0];
        win.col = c[9:0];
        win.last_run = (a == rn - 1 && b == cn - 1);
        win.last_plane = (r == hout - 1 && c == wout - 1);
        pending_windows.insert(pending_windows.size(), win);
        n++;
      end
    end
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= h) pos_row = 0;
    end
    return n;
  endfunction

  function automatic int gap_cycles(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one sample word until taken, then update the predictor
  task automatic send_sample(input logic [15:0] v, input int gap, input bit typed,
                             input logic [15:0] want);
    int n;
    window_t win;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    sample <= v;
    do @(posedge clk); while (full);
    samples_in++;
    n = pool_predict(v);
    // a typed row replaces the predicted window by the one written in the table
    if (typed) begin
      repeat (n) void'(pending_windows.pop_back());
      win.value = want;
      win.row = '0;
      win.col = '0;
      win.last_run = 1'b1;
      win.last_plane = 1'b1;
      pending_windows.insert(pending_windows.size(), win);
    end
  endtask

  // block is idle once every window is out and the last sample has drained
  task automatic settle();
    push <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_KERNEL:    kernel_reg = data[2:0];
      REG_STRIDE:    stride_reg = data[2:0];
      REG_PADDING:   padding_reg = data[1:0];
      REG_HEIGHT:    height_reg = data[10:0];
      REG_WIDTH:     width_reg = data[10:0];
      REG_PAD_VALUE: pad_reg = data;
      default:       return;
    endcase
    pos_row = 0;
    pos_col = 0;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // check each popped word against the oldest pending window
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_windows.size() == 0) begin
        report("unexpected word, row", out_row, -1);
      end else begin
        window_t w;
        w = pending_windows.pop_front();
        if (pooled_value !== w.value) report("pooled_value", pooled_value, w.value);
        if (out_row !== w.row) report("out_row", out_row, w.row);
        if (out_col !== w.col) report("out_col", out_col, w.col);
        if (last_in_run !== w.last_run) report("last_in_run", last_in_run, w.last_run);
        if (last_of_plane !== w.last_plane) report("last_of_plane", last_of_plane, w.last_plane);
      end
      windows_out++;
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("max_pool_2d_padded test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random pops, short and long stalls, and one long hold-off
  // once the random planes are streaming so that the input backs up
  initial begin
    int stall;
    bit held;
    stall = 0;
    held = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held && samples_in >= 40) begin
        held = 1;
        stall = 400;
      end
      if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        stall = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  stim_row_t dir_tab[$];

  function automatic void add_row(input row_kind_t kind, input logic [2:0] idx,
                                  input logic [15:0] data, input bit typed,
                                  input logic [15:0] want);
    stim_row_t row;
    row.kind = kind;
    row.idx = idx;
    row.data = data;
    row.typed = typed;
    row.want = want;
    dir_tab.insert(dir_tab.size(), row);
  endfunction

  initial begin
    int k, s, h, w, count;
    bit burst;
    kernel_reg = KERNEL_RST;
    stride_reg = STRIDE_RST;
    padding_reg = PADDING_RST;
    height_reg = HEIGHT_RST;
    width_reg = WIDTH_RST;
    pad_reg = PAD_VALUE_RST;
    pos_row = 0;
    pos_col = 0;

    // after reset: 1024 x 1024 plane, extremes only fill the line store
    add_row(ROW_SAMPLE, 3'd0, 16'h7fff, 1'b0, 16'h0);
    add_row(ROW_SAMPLE, 3'd0, 16'h8000, 1'b0, 16'h0);
    // 1x1 plane with a 1x1 window: every word comes straight back
    add_row(ROW_CFG, REG_KERNEL, 16'd1, 1'b0, 16'h0);
    add_row(ROW_CFG, REG_STRIDE, 16'd1, 1'b0, 16'h0);
    add_row(ROW_CFG, REG_PADDING, 16'd0, 1'b0, 16'h0);
    add_row(ROW_CFG, REG_HEIGHT, 16'd1, 1'b0, 16'h0);
    add_row(ROW_CFG, REG_WIDTH, 16'd1, 1'b0, 16'h0);
    add_row(ROW_SAMPLE, 3'd0, 16'h8000, 1'b1, 16'h8000);
    add_row(ROW_SAMPLE, 3'd0, 16'h7fff, 1'b1, 16'h7fff);
    // zero kernel and zero stride count as one
    add_row(ROW_CFG, REG_KERNEL, 16'd0, 1'b0, 16'h0);
    add_row(ROW_CFG, REG_STRIDE, 16'd0, 1'b0, 16'h0);
    add_row(ROW_SAMPLE, 3'd0, 16'hffff, 1'b1, 16'hffff);
    // zero plane size counts as one
    add_row(ROW_CFG, REG_HEIGHT, 16'd0, 1'b0, 16'h0);
    add_row(ROW_CFG, REG_WIDTH, 16'd0, 1'b0, 16'h0);
    add_row(ROW_SAMPLE, 3'd0, 16'h0001, 1'b1, 16'h0001);
    // largest kernel and padding on a 2x2 plane, most negative pad value
    add_row(ROW_CFG, REG_KERNEL, 16'd7, 1'b0, 16'h0);
    add_row(ROW_CFG, REG_PADDING, 16'd3, 1'b0, 16'h0);
    add_row(ROW_CFG, REG_HEIGHT, 16'd2, 1'b0, 16'h0);
    add_row(ROW_CFG, REG_WIDTH, 16'd2, 1'b0, 16'h0);
    add_row(ROW_CFG, REG_PAD_VALUE, 16'h8000, 1'b0, 16'h0);
    for (int i = 0; i < 4; i++)
      add_row(ROW_SAMPLE, 3'd0, 16'h8000 + 16'(i * 3), 1'b0, 16'h0);
    // no padding: plane smaller than the window, nothing comes out
    add_row(ROW_CFG, REG_PADDING, 16'd0, 1'b0, 16'h0);
    add_row(ROW_SAMPLE, 3'd0, 16'h1234, 1'b0, 16'h0);
    add_row(ROW_SAMPLE, 3'd0, 16'h7fff, 1'b0, 16'h0);
    // unknown register indexes change nothing
    add_row(ROW_CFG, 3'd6, 16'hffff, 1'b0, 16'h0);
    add_row(ROW_CFG, 3'd7, 16'h0000, 1'b0, 16'h0);
    add_row(ROW_SAMPLE, 3'd0, 16'h0100, 1'b0, 16'h0);
    // padding above half the kernel is cut down to it
    add_row(ROW_CFG, REG_KERNEL, 16'd3, 1'b0, 16'h0);
    add_row(ROW_CFG, REG_PADDING, 16'd3, 1'b0, 16'h0);
    for (int i = 0; i < 4; i++)
      add_row(ROW_SAMPLE, 3'd0, 16'(i * 16'h2345), 1'b0, 16'h0);
    // oversize height is clamped, upper data bits of the word ignored
    add_row(ROW_CFG, REG_HEIGHT, 16'hffff, 1'b0, 16'h0);
    add_row(ROW_SAMPLE, 3'd0, 16'h5a5a, 1'b0, 16'h0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) write_reg(dir_tab[i].idx, dir_tab[i].data);
      else send_sample(dir_tab[i].data, gap_cycles(0), dir_tab[i].typed, dir_tab[i].want);
    end

    // random geometries, mostly whole planes with random content
    count = 0;
    while (count < RAND_ITEMS) begin
      k = $urandom_range(1, 7);
      s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 3);
      h = $urandom_range(1, 9);
      w = $urandom_range(1, 9);
      write_reg(REG_KERNEL, 16'($urandom) & 16'hfff8 | 16'(k));
      write_reg(REG_STRIDE, 16'(s));
      write_reg(REG_PADDING, 16'($urandom_range(0, 3)));
      write_reg(REG_HEIGHT, 16'(h));
      write_reg(REG_WIDTH, 16'(w));
      if ($urandom_range(0, 1)) write_reg(REG_PAD_VALUE, rand_sample());
      if ($urandom_range(0, 7) == 0) write_reg(3'($urandom_range(6, 7)), 16'($urandom));
      burst = ($urandom_range(0, 3) == 0);
      // usually one or two full planes, sometimes a plane cut short
      if ($urandom_range(0, 4) == 0) s = $urandom_range(1, h * w);
      else s = h * w * $urandom_range(1, 2);
      for (int i = 0; i < s && count < RAND_ITEMS; i++) begin
        send_sample(rand_sample(), gap_cycles(burst), 1'b0, 16'h0);
        count++;
      end
    end

    settle();
    if (errors == 0) begin
      $display("max_pool_2d_padded test passed");
    end else begin
      $display("max_pool_2d_padded test failed");
    end
    $finish;
  end

endmodule
